// ===== design/dll_pkg.sv =====
package dll_pkg;

    // Fixed widths of the result fields.
    localparam int unsigned LINE_NO_W = 24;
    localparam int unsigned KIND_W    = 4;

    // Result queue depth; an item may push two results.
    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_PTR_W = 2;
    localparam int unsigned Q_CNT_W = 3;

    // Token kinds that the lexer produces outside the keyword table.
    localparam logic [KIND_W-1:0] TOKEN_EOF  = 4'd0;
    localparam logic [KIND_W-1:0] TOKEN_PLAIN = 4'd1;

    // Input item kinds.
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // Bytes with a meaning of their own.
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_LO_A = 8'h61;
    localparam logic [7:0] CH_LO_Z = 8'h7A;

    localparam int unsigned NUM_KW = 14;

    typedef struct packed {
        logic [KIND_W-1:0]    token_kind;
        logic [LINE_NO_W-1:0] line_number;
        logic [7:0]           char_value;
        logic                 has_char;
        logic                 token_end;
    } res_t;

    // Keyword names, first letter in the lowest byte, zero padded to 8 bytes.
    localparam logic [63:0] KW_NAME [NUM_KW] = '{
        64'h0065_6475_6c63_6e69, // include
        64'h0000_0000_0062_696c, // lib
        64'h0000_6e72_6574_7865, // extern
        64'h0000_656e_6966_6564, // define
        64'h0000_0066_6564_6e75, // undef
        64'h0000_0066_6564_6669, // ifdef
        64'h0000_6665_646e_6669, // ifndef
        64'h0000_0000_0000_6669, // if
        64'h0000_0000_6669_6c65, // elif
        64'h0000_0000_6573_6c65, // else
        64'h0000_0066_6964_6e65, // endif
        64'h0000_0072_6f72_7265, // error
        64'h0000_616d_6761_7270, // pragma
        64'h0000_0000_656e_696c  // line
    };

    localparam logic [3:0] KW_LEN [NUM_KW] = '{
        4'd7, 4'd3, 4'd6, 4'd6, 4'd5, 4'd5, 4'd6,
        4'd2, 4'd4, 4'd4, 4'd5, 4'd5, 4'd6, 4'd4
    };

    localparam logic [KIND_W-1:0] KW_CODE [NUM_KW] = '{
        4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8,
        4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15
    };

    // The name buffer is zero beyond its length, so a whole-word compare
    // with a matching length is an exact match. Zero means no keyword.
    function automatic logic [KIND_W-1:0] keyword_code(input logic [63:0] name,
                                                       input logic [3:0]  len);
        logic [KIND_W-1:0] code;
        code = TOKEN_EOF;
        for (int i = 0; i < NUM_KW; i++) begin
            if ((len == KW_LEN[i]) && (name == KW_NAME[i])) begin
                code = KW_CODE[i];
            end
        end
        return code;
    endfunction

endpackage

// ===== design/dll_lex.sv =====
module dll_lex #(
    parameter int unsigned LINE_WIDTH = 24,
    parameter int unsigned NAME_MAX   = 7
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step,
    input  logic          is_end,
    input  logic [7:0]    byte_value,
    output logic [1:0]    res_count,
    output dll_pkg::res_t res0,
    output dll_pkg::res_t res1
);

    localparam int unsigned NL_W = $clog2(NAME_MAX + 2);
    localparam int unsigned NB_W = NAME_MAX * 8;

    typedef enum logic [2:0] {
        PH_LEAD,
        PH_TEXT,
        PH_HASH,
        PH_NAME,
        PH_RESTWS,
        PH_BODY,
        PH_SKIP
    } phase_t;

    phase_t                     phase_reg, phase_next;
    logic [NB_W-1:0]            name_buf_reg, name_buf_next;
    logic [NL_W-1:0]            name_len_reg, name_len_next;
    logic [dll_pkg::KIND_W-1:0] dir_kind_reg, dir_kind_next;
    logic                       cr_pend_reg, cr_pend_next;
    logic [LINE_WIDTH-1:0]      line_cnt_reg, line_cnt_next;
    logic                       line_open_reg, line_open_next;

    logic [dll_pkg::KIND_W-1:0] lk_kind;
    logic                       close_emit;
    logic [dll_pkg::KIND_W-1:0] close_kind;
    logic                       is_blank;
    logic                       is_lower;
    logic [31:0]                cnt32;
    logic [dll_pkg::LINE_NO_W-1:0] line_no;
    dll_pkg::res_t              res_v [2];
    logic [1:0]                 n;

    function automatic dll_pkg::res_t make_res(input logic [dll_pkg::KIND_W-1:0] kind,
                                               input logic [dll_pkg::LINE_NO_W-1:0] ln,
                                               input logic [7:0] ch,
                                               input logic has,
                                               input logic fin);
        dll_pkg::res_t r;
        r.token_kind  = kind;
        r.line_number = ln;
        r.char_value  = ch;
        r.has_char    = has;
        r.token_end   = fin;
        return r;
    endfunction

    assign lk_kind  = dll_pkg::keyword_code(64'(name_buf_reg), 4'(name_len_reg));
    assign is_blank = (byte_value == dll_pkg::CH_SP) || (byte_value == dll_pkg::CH_TAB);
    assign is_lower = (byte_value >= dll_pkg::CH_LO_A) && (byte_value <= dll_pkg::CH_LO_Z);

    // What closing the current line would send, from the stored state alone.
    always_comb
    begin
        close_emit = 1'b0;
        close_kind = dir_kind_reg;
        case (phase_reg)
            PH_TEXT, PH_RESTWS, PH_BODY:
            begin
                close_emit = 1'b1;
            end
            PH_HASH, PH_NAME:
            begin
                close_emit = (lk_kind != dll_pkg::TOKEN_EOF);
                close_kind = lk_kind;
            end
            default:
            begin
                close_emit = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        phase_next     = phase_reg;
        name_buf_next  = name_buf_reg;
        name_len_next  = name_len_reg;
        dir_kind_next  = dir_kind_reg;
        cr_pend_next   = cr_pend_reg;
        line_cnt_next  = line_cnt_reg;
        line_open_next = line_open_reg;
        res_v[0]       = '0;
        res_v[1]       = '0;
        n              = 2'd0;
        cnt32          = 32'(line_cnt_reg);
        line_no        = cnt32[dll_pkg::LINE_NO_W-1:0];

        if (step)
        begin
            if (is_end == dll_pkg::KIND_END)
            begin
                if (line_open_reg && close_emit)
                begin
                    res_v[n[0]] = make_res(close_kind, line_no, 8'h00, 1'b0, 1'b1);
                    n = n + 2'd1;
                end
                res_v[n[0]] = make_res(dll_pkg::TOKEN_EOF, line_no, 8'h00, 1'b0, 1'b1);
                n = n + 2'd1;
                phase_next     = PH_LEAD;
                name_buf_next  = '0;
                name_len_next  = '0;
                dir_kind_next  = '0;
                cr_pend_next   = 1'b0;
                line_cnt_next  = '0;
                line_open_next = 1'b0;
            end
            else
            begin
                if (!line_open_reg)
                begin
                    line_open_next = 1'b1;
                    if (line_cnt_reg != '1)
                    begin
                        line_cnt_next = line_cnt_reg + 1'b1;
                    end
                end
                cnt32   = 32'(line_cnt_next);
                line_no = cnt32[dll_pkg::LINE_NO_W-1:0];

                if (byte_value == dll_pkg::CH_LF)
                begin
                    if (close_emit)
                    begin
                        res_v[n[0]] = make_res(close_kind, line_no, 8'h00, 1'b0, 1'b1);
                        n = n + 2'd1;
                    end
                    phase_next     = PH_LEAD;
                    name_buf_next  = '0;
                    name_len_next  = '0;
                    dir_kind_next  = '0;
                    cr_pend_next   = 1'b0;
                    line_open_next = 1'b0;
                end
                else
                begin
                    // A held carriage return not followed by a newline is content.
                    if (cr_pend_reg)
                    begin
                        cr_pend_next = 1'b0;
                        if (phase_reg == PH_LEAD)
                        begin
                            dir_kind_next = dll_pkg::TOKEN_PLAIN;
                            phase_next    = PH_TEXT;
                        end
                        else if (phase_reg == PH_RESTWS)
                        begin
                            phase_next = PH_BODY;
                        end
                        res_v[n[0]] = make_res(dir_kind_next, line_no, dll_pkg::CH_CR,
                                               1'b1, 1'b0);
                        n = n + 2'd1;
                    end

                    case (phase_next)
                        PH_LEAD:
                        begin
                            if (is_blank)
                            begin
                            end
                            else if (byte_value == dll_pkg::CH_CR)
                            begin
                                cr_pend_next = 1'b1;
                            end
                            else if (byte_value == dll_pkg::CH_HASH)
                            begin
                                phase_next = PH_HASH;
                            end
                            else
                            begin
                                dir_kind_next = dll_pkg::TOKEN_PLAIN;
                                phase_next    = PH_TEXT;
                                res_v[n[0]] = make_res(dll_pkg::TOKEN_PLAIN, line_no,
                                                       byte_value, 1'b1, 1'b0);
                                n = n + 2'd1;
                            end
                        end
                        PH_TEXT, PH_BODY:
                        begin
                            if (byte_value == dll_pkg::CH_CR)
                            begin
                                cr_pend_next = 1'b1;
                            end
                            else
                            begin
                                res_v[n[0]] = make_res(dir_kind_next, line_no,
                                                       byte_value, 1'b1, 1'b0);
                                n = n + 2'd1;
                            end
                        end
                        PH_HASH, PH_NAME:
                        begin
                            if ((phase_next == PH_HASH) && is_blank)
                            begin
                            end
                            else if (is_lower)
                            begin
                                phase_next = PH_NAME;
                                if (name_len_reg < NL_W'(NAME_MAX))
                                begin
                                    name_buf_next[name_len_reg*8 +: 8] = byte_value;
                                    name_len_next = name_len_reg + 1'b1;
                                end
                                else
                                begin
                                    name_len_next = NL_W'(NAME_MAX + 1);
                                end
                            end
                            else
                            begin
                                dir_kind_next = lk_kind;
                                if (lk_kind == dll_pkg::TOKEN_EOF)
                                begin
                                    phase_next = PH_SKIP;
                                end
                                else if (is_blank)
                                begin
                                    phase_next = PH_RESTWS;
                                end
                                else if (byte_value == dll_pkg::CH_CR)
                                begin
                                    phase_next   = PH_RESTWS;
                                    cr_pend_next = 1'b1;
                                end
                                else
                                begin
                                    phase_next = PH_BODY;
                                    res_v[n[0]] = make_res(lk_kind, line_no,
                                                           byte_value, 1'b1, 1'b0);
                                    n = n + 2'd1;
                                end
                            end
                        end
                        PH_RESTWS:
                        begin
                            if (is_blank)
                            begin
                            end
                            else if (byte_value == dll_pkg::CH_CR)
                            begin
                                cr_pend_next = 1'b1;
                            end
                            else
                            begin
                                phase_next = PH_BODY;
                                res_v[n[0]] = make_res(dir_kind_next, line_no,
                                                       byte_value, 1'b1, 1'b0);
                                n = n + 2'd1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
        end
    end

    assign res_count = n;
    assign res0      = res_v[0];
    assign res1      = res_v[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_LEAD;
            name_buf_reg  <= '0;
            name_len_reg  <= '0;
            dir_kind_reg  <= '0;
            cr_pend_reg   <= 1'b0;
            line_cnt_reg  <= '0;
            line_open_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            name_buf_reg  <= name_buf_next;
            name_len_reg  <= name_len_next;
            dir_kind_reg  <= dir_kind_next;
            cr_pend_reg   <= cr_pend_next;
            line_cnt_reg  <= line_cnt_next;
            line_open_reg <= line_open_next;
        end
    end

endmodule

// ===== design/dll_res_queue.sv =====
module dll_res_queue (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [1:0]                    push_count,
    input  dll_pkg::res_t                 push0,
    input  dll_pkg::res_t                 push1,
    input  logic                          pop,
    output dll_pkg::res_t                 head,
    output logic [dll_pkg::Q_CNT_W-1:0]   count
);

    dll_pkg::res_t                 mem [dll_pkg::Q_DEPTH];
    logic [dll_pkg::Q_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [dll_pkg::Q_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [dll_pkg::Q_CNT_W-1:0]   count_reg, count_next;
    logic [dll_pkg::Q_PTR_W-1:0]   wr_ptr_plus1;

    assign wr_ptr_plus1 = wr_ptr_reg + 1'b1;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + push_count;
        rd_ptr_next = rd_ptr_reg + {1'b0, pop};
        count_next  = count_reg + dll_pkg::Q_CNT_W'(push_count)
                      - dll_pkg::Q_CNT_W'(pop);
    end

    // Payload storage, no reset needed.
    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
        begin
            mem[wr_ptr_reg] <= push0;
        end
        if (push_count == 2'd2)
        begin
            mem[wr_ptr_plus1] <= push1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign head  = mem[rd_ptr_reg];
    assign count = count_reg;

endmodule

// ===== design/directive_line_lexer_top.sv =====
// Directive line lexer. Bytes enter on the s_ side (tuser = 0 for a byte,
// tuser = 1 for end of input) and line tokens leave on the m_ side as one
// transaction per content byte followed by a terminator transaction with
// tlast high. Lines that start with '#' and a known keyword become directive
// tokens; lines with '#' and an unknown or missing name are skipped; other
// non-blank lines become TEXT tokens; end of input closes any open line, sends
// an EOF token carrying the line count and returns the block to its reset state,
// so that a new stream may follow at once. Each input transaction is captured in
// an input register; once the queue has room, it updates the lexer state and its
// results are written into a four-entry result queue, which the m_ side reads.
// The block accepts one byte per cycle whenever each byte yields at most one
// result and the output side keeps up; a byte that releases a held carriage
// return may yield two results, as does an end of input that closes an open
// token, and both results leave in turn. The input stalls while the queue could
// not take two more results.
module directive_line_lexer_top #(
    parameter int unsigned LINE_WIDTH = 24,
    parameter int unsigned NAME_MAX   = 7
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_value
    input  logic        s_tuser,   // [0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [23:0] line_number, [31:24] char_value
    output logic [4:0]  m_tuser,   // [3:0] token_kind, [4] has_char
    output logic        m_tlast    // token_end
);

    logic                        in_valid_reg;
    logic                        in_end_reg;
    logic [7:0]                  in_byte_reg;
    logic                        fire;
    logic [1:0]                  res_count;
    dll_pkg::res_t               res0;
    dll_pkg::res_t               res1;
    dll_pkg::res_t               head;
    logic [dll_pkg::Q_CNT_W-1:0] q_count;
    logic                        pop;

    // The held item is processed once the queue has room for two results.
    assign fire     = in_valid_reg
                      && (q_count <= dll_pkg::Q_CNT_W'(dll_pkg::Q_DEPTH - 2));
    assign s_tready = !in_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_end_reg  <= s_tuser;
            in_byte_reg <= s_tdata;
        end
    end

    dll_lex #(
        .LINE_WIDTH (LINE_WIDTH),
        .NAME_MAX   (NAME_MAX)
    ) u_lex (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (fire),
        .is_end     (in_end_reg),
        .byte_value (in_byte_reg),
        .res_count  (res_count),
        .res0       (res0),
        .res1       (res1)
    );

    dll_res_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_count (res_count),
        .push0      (res0),
        .push1      (res1),
        .pop        (pop),
        .head       (head),
        .count      (q_count)
    );

    assign m_tvalid = (q_count != '0);
    assign pop      = m_tvalid && m_tready;
    assign m_tdata  = {head.char_value, head.line_number};
    assign m_tuser  = {head.has_char, head.token_kind};
    assign m_tlast  = head.token_end;

endmodule

// ===== design/dll_checker.sv =====
module dll_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [4:0]  m_tuser,
    input logic        m_tlast
);

    // A content byte never closes a token, and a terminator never carries one.
    a_end_xor_char: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser[4] != m_tlast))
        else $error("token_end and has_char disagree");

    // A terminator carries a zero byte.
    a_term_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[4]) |-> (m_tdata[31:24] == 8'h00))
        else $error("terminator with non-zero char_value");

    // EOF is always a bare terminator.
    a_eof_bare: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser[3:0] == 4'd0)) |-> (!m_tuser[4] && m_tlast))
        else $error("EOF token carries content");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                     && $stable(m_tlast)))
        else $error("result changed while stalled");

endmodule

bind directive_line_lexer_top dll_checker u_dll_checker (.*);

// ===== sim/directive_line_lexer_top_test.sv =====
module directive_line_lexer_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    import dll_pkg::*;

    // Token kinds as they appear on the result side.
    typedef enum logic [3:0] {
        TK_EOF     = 4'd0,
        TK_TEXT    = 4'd1,
        TK_INCLUDE = 4'd2,
        TK_LIB     = 4'd3,
        TK_EXTERN  = 4'd4,
        TK_DEFINE  = 4'd5,
        TK_UNDEF   = 4'd6,
        TK_IFDEF   = 4'd7,
        TK_IFNDEF  = 4'd8,
        TK_IF      = 4'd9,
        TK_ELIF    = 4'd10,
        TK_ELSE    = 4'd11,
        TK_ENDIF   = 4'd12,
        TK_ERROR   = 4'd13,
        TK_PRAGMA  = 4'd14,
        TK_LINE    = 4'd15
    } token_e;

    // Where the lexer stands within the current line.
    typedef enum logic [2:0] {
        LX_LEAD,
        LX_TEXT,
        LX_HASH,
        LX_NAME,
        LX_RESTWS,
        LX_BODY,
        LX_SKIP
    } lex_phase_e;

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
    } item_t;

    // One row of the directed table; a typed row carries its one token result.
    typedef struct packed {
        logic       kind;
        logic [7:0] data;
        logic       typed;
        res_t       want;
    } row_t;

    localparam int NAME_LIMIT = 7;
    localparam int DIR_ROWS   = 24;
    localparam int RANDOM_ITEMS = 2000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tuser = KIND_BYTE;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [4:0]  m_tuser;
    logic        m_tlast;

    directive_line_lexer_top DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Lexer state as predicted by the testbench.
    lex_phase_e           ph;
    logic [55:0]          name_buf;
    int                   name_len;
    logic [3:0]           dir_kind;
    logic                 cr_held;
    logic [LINE_NO_W-1:0] line_cnt;
    logic                 line_open;

    res_t  step_tokens [$];   // token results caused by the latest transaction
    res_t  token_q [$];       // token results still awaited from the block
    item_t line_items [$];    // input transactions of the line being built

    int  fail_count = 0;
    int  random_sent = 0;
    bit  calm = 1'b0;          // no idling on either side
    int  sink_hold = 0;
    res_t head;

    string kw_words [14] = '{"include", "lib", "extern", "define", "undef", "ifdef",
                             "ifndef", "if", "elif", "else", "endif", "error",
                             "pragma", "line"};

    row_t dir_rows [DIR_ROWS] = '{
        // End of input straight after reset: an EOF token with no lines.
        '{KIND_END,  8'h00, 1'b1, '{TK_EOF,  24'd0, 8'h00, 1'b0, 1'b1}},
        '{KIND_BYTE, 8'hFF, 1'b1, '{TK_TEXT, 24'd1, 8'hFF, 1'b1, 1'b0}},
        '{KIND_BYTE, 8'h00, 1'b0, '0},   // a zero byte is plain content
        '{KIND_BYTE, CH_CR, 1'b0, '0},   // held, then released by the next byte
        '{KIND_BYTE, 8'h61, 1'b0, '0},
        '{KIND_BYTE, CH_CR, 1'b0, '0},   // dropped by the newline after it
        '{KIND_BYTE, CH_LF, 1'b1, '{TK_TEXT, 24'd1, 8'h00, 1'b0, 1'b1}},
        '{KIND_BYTE, CH_TAB, 1'b0, '0},
        '{KIND_BYTE, CH_HASH, 1'b0, '0},
        '{KIND_BYTE, CH_SP, 1'b0, '0},
        '{KIND_BYTE, 8'h69, 1'b0, '0},
        '{KIND_BYTE, 8'h66, 1'b0, '0},
        '{KIND_BYTE, CH_CR, 1'b0, '0},   // ends the name but is not a blank
        // Directive with no content: the terminator alone.
        '{KIND_BYTE, CH_LF, 1'b1, '{TK_IF, 24'd2, 8'h00, 1'b0, 1'b1}},
        '{KIND_BYTE, CH_HASH, 1'b0, '0},
        '{KIND_BYTE, 8'h78, 1'b0, '0},   // unknown name, line skipped
        '{KIND_BYTE, CH_LF, 1'b0, '0},
        '{KIND_BYTE, CH_LF, 1'b0, '0},   // empty line
        '{KIND_BYTE, CH_HASH, 1'b0, '0},
        '{KIND_BYTE, 8'h65, 1'b0, '0},
        '{KIND_BYTE, 8'h6C, 1'b0, '0},
        '{KIND_BYTE, 8'h73, 1'b0, '0},
        '{KIND_BYTE, 8'h65, 1'b0, '0},
        // End of input inside a name: closes the directive, then EOF.
        '{KIND_END,  8'hFF, 1'b0, '0}
    };

    function automatic logic [3:0] keyword_of(input logic [55:0] nm, input int len);
        if (len == 0 || len > NAME_LIMIT)
            return TK_EOF;
        case (nm)
            "include": return TK_INCLUDE;
            "lib":     return TK_LIB;
            "extern":  return TK_EXTERN;
            "define":  return TK_DEFINE;
            "undef":   return TK_UNDEF;
            "ifdef":   return TK_IFDEF;
            "ifndef":  return TK_IFNDEF;
            "if":      return TK_IF;
            "elif":    return TK_ELIF;
            "else":    return TK_ELSE;
            "endif":   return TK_ENDIF;
            "error":   return TK_ERROR;
            "pragma":  return TK_PRAGMA;
            "line":    return TK_LINE;
            default:   return TK_EOF;
        endcase
    endfunction

    function automatic bit is_blank(input logic [7:0] b);
        return (b == CH_SP) || (b == CH_TAB);
    endfunction

    task automatic emit(input logic [3:0] kind, input logic [7:0] ch,
                        input logic has, input logic fin);
        res_t r;
        r.token_kind  = kind;
        r.line_number = line_cnt;
        r.char_value  = ch;
        r.has_char    = has;
        r.token_end   = fin;
        step_tokens.push_back(r);
    endtask

    task automatic start_line();
        ph        = LX_LEAD;
        name_buf  = '0;
        name_len  = 0;
        dir_kind  = TK_EOF;
        cr_held   = 1'b0;
        line_open = 1'b0;
    endtask

    task automatic close_line();
        logic [3:0] k;
        case (ph)
            LX_TEXT, LX_RESTWS, LX_BODY: emit(dir_kind, 8'h00, 1'b0, 1'b1);
            LX_HASH, LX_NAME:
            begin
                k = keyword_of(name_buf, name_len);
                if (k != TK_EOF)
                    emit(k, 8'h00, 1'b0, 1'b1);
            end
            default: ;
        endcase
        start_line();
    endtask

    // After a known name: blanks are skipped, a carriage return is held, and the first other byte opens the body.
    task automatic rest_of_directive(input logic [7:0] b);
        if (is_blank(b))
            ;
        else if (b == CH_CR)
            cr_held = 1'b1;
        else
        begin
            ph = LX_BODY;
            emit(dir_kind, b, 1'b1, 1'b0);
        end
    endtask

    task automatic take_byte(input logic [7:0] b);
        case (ph)
            LX_LEAD:
            begin
                if (is_blank(b))
                    ;
                else if (b == CH_CR)
                    cr_held = 1'b1;
                else if (b == CH_HASH)
                    ph = LX_HASH;
                else
                begin
                    dir_kind = TK_TEXT;
                    ph = LX_TEXT;
                    emit(dir_kind, b, 1'b1, 1'b0);
                end
            end
            LX_TEXT, LX_BODY:
            begin
                if (b == CH_CR)
                    cr_held = 1'b1;
                else
                    emit(dir_kind, b, 1'b1, 1'b0);
            end
            LX_HASH, LX_NAME:
            begin
                if (ph == LX_HASH && is_blank(b))
                    ;
                else if (b >= CH_LO_A && b <= CH_LO_Z)
                begin
                    ph = LX_NAME;
                    if (name_len < NAME_LIMIT)
                    begin
                        name_buf = {name_buf[47:0], b};
                        name_len++;
                    end
                    else
                        name_len = NAME_LIMIT + 1;
                end
                else
                begin
                    dir_kind = keyword_of(name_buf, name_len);
                    if (dir_kind == TK_EOF)
                        ph = LX_SKIP;
                    else
                    begin
                        ph = LX_RESTWS;
                        rest_of_directive(b);
                    end
                end
            end
            LX_RESTWS: rest_of_directive(b);
            default: ;
        endcase
    endtask

    // Works out the token results of one accepted input transaction.
    task automatic lex_step(input logic kind, input logic [7:0] b);
        step_tokens.delete();
        if (kind == KIND_END)
        begin
            if (line_open)
                close_line();
            emit(TK_EOF, 8'h00, 1'b0, 1'b1);
            start_line();
            line_cnt = '0;
        end
        else
        begin
            if (!line_open)
            begin
                line_open = 1'b1;
                if (line_cnt != {LINE_NO_W{1'b1}})
                    line_cnt++;
            end
            if (b == CH_LF)
                close_line();
            else
            begin
                // A held carriage return that is not followed by a newline is content.
                if (cr_held)
                begin
                    cr_held = 1'b0;
                    if (ph == LX_LEAD)
                    begin
                        dir_kind = TK_TEXT;
                        ph = LX_TEXT;
                    end
                    else if (ph == LX_RESTWS)
                        ph = LX_BODY;
                    emit(dir_kind, CH_CR, 1'b1, 1'b0);
                end
                take_byte(b);
            end
        end
    endtask

    // Offers one transaction, records its expected results once it is accepted,
    // then perhaps idles for a burst of cycles.
    task automatic send_item(input item_t it, input logic typed, input res_t want);
        s_tvalid <= 1'b1;
        s_tdata  <= it.data;
        s_tuser  <= it.kind;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        lex_step(it.kind, it.data);
        if (typed)
            token_q.push_back(want);
        else
            foreach (step_tokens[i])
                token_q.push_back(step_tokens[i]);
        if (!calm && $urandom_range(0, 9) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16))
                @(posedge clk);
        end
    endtask

    // Holds the sender back until every awaited result has come out.
    task automatic drain_tokens();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (token_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic put_byte(input logic [7:0] b);
        line_items.push_back('{KIND_BYTE, b});
    endtask

    task automatic put_word(input string w);
        for (int i = 0; i < w.len(); i++)
            put_byte(w[i]);
    endtask

    task automatic put_blanks(input int lo, input int hi);
        repeat ($urandom_range(lo, hi))
            put_byte(($urandom_range(0, 1) != 0) ? CH_SP : CH_TAB);
    endtask

    // Content of a line: mostly printable, with the odd blank, carriage
    // return or arbitrary byte mixed in.
    task automatic put_body();
        int r;
        repeat ($urandom_range(0, 10))
        begin
            r = $urandom_range(0, 15);
            if (r == 0)
                put_byte(CH_CR);
            else if (r == 1)
                put_byte(8'($urandom_range(0, 255)));
            else if (r == 2)
                put_byte(CH_SP);
            else
                put_byte(8'($urandom_range(8'h21, 8'h7E)));
        end
    endtask

    // Builds one random line. Half are directive lines, most of them with a
    // real keyword, so that the name and body states are well exercised.
    task automatic gen_line();
        int sel;
        int pick;
        int e;
        sel = $urandom_range(0, 99);
        put_blanks(0, 2);
        if (sel < 50)
        begin
            put_byte(CH_HASH);
            put_blanks(0, 2);
            pick = $urandom_range(0, 19);
            if (pick < 14)
                put_word(kw_words[pick]);
            else if (pick < 16)
                repeat ($urandom_range(1, 10))
                    put_byte(8'($urandom_range(CH_LO_A, CH_LO_Z)));
            else if (pick == 16)
            begin
                // A keyword with extra letters: too long, or simply unknown.
                put_word(kw_words[$urandom_range(0, 13)]);
                repeat ($urandom_range(1, 3))
                    put_byte(8'($urandom_range(CH_LO_A, CH_LO_Z)));
            end
            else if (pick == 18)
            begin
                // A keyword followed at once by a byte that is no lowercase letter, which opens the body.
                put_word(kw_words[$urandom_range(0, 13)]);
                put_byte(8'($urandom_range(8'h21, 8'h60)));
            end
            else if (pick == 19)
                put_byte(8'($urandom_range(0, 255)));
            e = $urandom_range(0, 3);
            if (e == 1)
                put_blanks(1, 3);
            else if (e == 2)
                put_byte(CH_CR);
            put_body();
        end
        else if (sel < 80)
        begin
            put_byte(8'($urandom_range(8'h21, 8'h7E)));
            put_body();
        end
        else if (sel < 90)
            put_blanks(0, 3);
        else
            repeat ($urandom_range(1, 12))
                put_byte(8'($urandom_range(0, 255)));
        e = $urandom_range(0, 99);
        if (e < 8)
            put_byte(CH_CR);
        if (e < 94)
            put_byte(CH_LF);
        else
        begin
            if (e >= 97)
                put_byte(CH_LF);
            line_items.push_back('{KIND_END, 8'($urandom_range(0, 255))});
        end
    endtask

    task automatic check_field(input string field, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            fail_count++;
        end
    endtask

    // The receiver stalls in random bursts, except in the calm part.
    always @(posedge clk)
    begin
        if (sink_hold > 0)
        begin
            sink_hold <= sink_hold - 1;
            m_tready  <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 15) == 0)
        begin
            sink_hold <= $urandom_range(0, 15);
            m_tready  <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // Every result transaction is matched against the oldest awaited token result.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (token_q.size() == 0)
            begin
                $error("result with no token result awaited: kind %0d line %0d char %0d",
                       m_tuser[3:0], m_tdata[23:0], m_tdata[31:24]);
                fail_count++;
            end
            else
            begin
                head = token_q.pop_front();
                check_field("token_kind", head.token_kind, m_tuser[3:0]);
                check_field("line_number", head.line_number, m_tdata[23:0]);
                check_field("char_value", head.char_value, m_tdata[31:24]);
                check_field("has_char", head.has_char, m_tuser[4]);
                check_field("token_end", head.token_end, m_tlast);
            end
        end
    end

    initial
    begin
        int wait_cycles;
        start_line();
        line_cnt = '0;
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_item('{dir_rows[i].kind, dir_rows[i].data}, dir_rows[i].typed,
                      dir_rows[i].want);
        drain_tokens();

        // Random lines; the last stretch runs with no idling on either side.
        while (random_sent < RANDOM_ITEMS)
        begin
            if (random_sent > RANDOM_ITEMS - 300)
                calm = 1'b1;
            line_items.delete();
            gen_line();
            if (!calm && $urandom_range(0, 49) == 0)
                drain_tokens();
            foreach (line_items[i])
                send_item(line_items[i], 1'b0, '0);
            random_sent += line_items.size();
        end

        s_tvalid <= 1'b0;
        wait_cycles = 0;
        @(posedge clk);
        while (token_q.size() != 0 && wait_cycles < 20000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (20)
            @(posedge clk);
        if (token_q.size() != 0)
        begin
            $error("%0d token results never arrived", token_q.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

// ===== files.f =====
design/dll_pkg.sv
design/dll_lex.sv
design/dll_res_queue.sv
design/directive_line_lexer_top.sv
design/dll_checker.sv
sim/directive_line_lexer_top_test.sv
